// ===== sv/bfe_pkg.sv =====
// Package: shared types, character codes and command/status structs.
package bfe_pkg;
  localparam int MAX_LEN_DEF  = 32;
  localparam int MAX_VARS_DEF = 16;

  localparam logic [7:0] CH_NOT = 8'h21;
  localparam logic [7:0] CH_AND = 8'h26;
  localparam logic [7:0] CH_OR  = 8'h7c;
  localparam logic [7:0] CH_XOR = 8'h5e;
  localparam logic [7:0] CH_IMP = 8'h3e;
  localparam logic [7:0] CH_EQV = 8'h7e;
  localparam logic [7:0] CH_LP  = 8'h28;
  localparam logic [7:0] CH_RP  = 8'h29;

  localparam logic       CMD_LOAD = 1'b0;
  localparam logic       CMD_EVAL = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LONG    = 2'd1;
  localparam logic [1:0] ST_VARS    = 2'd2;
  localparam logic [1:0] ST_MALFORM = 2'd3;

  typedef struct packed {
    logic        command;
    logic [7:0]  formula_char;
    logic        last_char;
    logic [15:0] assignment;
  } in_item_t;

  typedef struct packed {
    logic       value;
    logic [4:0] variable_count;
    logic [1:0] status;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;       // latch input item
    logic clear;      // start new formula
    logic store;      // write char at length
    logic scan_start; // reset variable scan
    logic scan_step;  // advance variable scan
    logic add_var;    // append new variable / flag
    logic eval_start; // reset evaluator
    logic eval_step;  // one evaluator step
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic scan_done;
    logic is_var;
    logic var_over;
    logic eval_done;
  } dp_sts_t;

  function automatic logic is_op(input logic [7:0] c);
    return c == CH_NOT || c == CH_AND || c == CH_OR || c == CH_XOR ||
           c == CH_IMP || c == CH_EQV || c == CH_LP || c == CH_RP;
  endfunction

  // Binary precedence: 5 for AND down to 1 for equivalence, 0 not binary.
  function automatic logic [2:0] prec(input logic [7:0] c);
    logic [2:0] p;
    p = 3'd0;
    if (c == CH_AND) p = 3'd5;
    if (c == CH_OR)  p = 3'd4;
    if (c == CH_XOR) p = 3'd3;
    if (c == CH_IMP) p = 3'd2;
    if (c == CH_EQV) p = 3'd1;
    return p;
  endfunction

  function automatic logic apply(input logic [7:0] op, input logic a, input logic b);
    logic r;
    r = ~(a ^ b);
    if (op == CH_AND) r = a & b;
    if (op == CH_OR)  r = a | b;
    if (op == CH_XOR) r = a ^ b;
    if (op == CH_IMP) r = ~a | b;
    return r;
  endfunction
endpackage

// ===== sv/bfe_datapath.sv =====
// Datapath: formula store, variable table, shunting-yard evaluator stacks.
module bfe_datapath #(
  parameter int MAX_LEN  = bfe_pkg::MAX_LEN_DEF,
  parameter int MAX_VARS = bfe_pkg::MAX_VARS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bfe_pkg::in_item_t in_item,
  input  bfe_pkg::dp_cmd_t  cmd,
  output bfe_pkg::dp_sts_t  sts,
  output logic [4:0]        var_total,
  output logic              eval_value,
  output logic              eval_bad
);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int VW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int SW = $clog2(MAX_LEN + 2);

  bfe_pkg::in_item_t item;
  logic [7:0]    fstore [MAX_LEN];
  logic [VW-1:0] wbuf   [MAX_LEN];
  logic [7:0]    vtab   [MAX_VARS];
  logic [LW-1:0] length;
  logic [4:0]    scan;
  logic          found;
  logic [VW-1:0] found_idx;

  // Evaluator state: pc over the formula, operator stack, value stack.
  logic [LW-1:0] pc;
  logic [7:0]    ostk [MAX_LEN];
  logic          vstk [MAX_LEN];
  logic [SW-1:0] osp, vsp;
  logic          expect_opnd, bad, done;
  logic [7:0]    cur, otop;
  logic          at_end;

  assign sts.full      = length == LW'(MAX_LEN);
  assign sts.is_var    = !bfe_pkg::is_op(item.formula_char);
  assign sts.var_over  = sts.is_var && !found && var_total >= 5'(MAX_VARS);
  assign sts.scan_done = found || (scan >= var_total) || (scan >= 5'(MAX_VARS));
  assign sts.eval_done = done;
  assign eval_value    = vstk[0];
  assign eval_bad      = bad;

  assign at_end = pc >= length;
  assign cur    = at_end ? 8'h00 : fstore[pc[AW-1:0]];
  assign otop   = (osp == '0) ? 8'h00 : ostk[osp[AW-1:0] - AW'(1)];

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item <= in_item;
    end
    if (rst || cmd.clear) begin
      length    <= '0;
      var_total <= '0;
    end else begin
      if (cmd.store) begin
        fstore[length[AW-1:0]] <= item.formula_char;
        wbuf[length[AW-1:0]]   <= found ? found_idx : VW'(var_total);
        length                 <= length + LW'(1);
      end
      if (cmd.add_var && !found && var_total < 5'(MAX_VARS)) begin
        vtab[var_total[VW-1:0]] <= item.formula_char;
        var_total               <= var_total + 5'd1;
      end
    end
    if (cmd.scan_start) begin
      scan  <= '0;
      found <= 1'b0;
    end else if (cmd.scan_step && !sts.scan_done) begin
      if (vtab[scan[VW-1:0]] == item.formula_char) begin
        found     <= 1'b1;
        found_idx <= scan[VW-1:0];
      end else begin
        scan <= scan + 5'd1;
      end
    end
    if (cmd.eval_start) begin
      pc          <= '0;
      osp         <= '0;
      vsp         <= '0;
      expect_opnd <= 1'b1;
      bad         <= 1'b0;
      done        <= 1'b0;
    end else if (cmd.eval_step && !done) begin
      if (bad) begin
        done <= 1'b1;
      end else if (expect_opnd) begin
        if (at_end) begin
          bad <= 1'b1;
        end else if (cur == bfe_pkg::CH_NOT || cur == bfe_pkg::CH_LP) begin
          ostk[osp[AW-1:0]] <= cur;
          osp <= osp + SW'(1);
          pc  <= pc + LW'(1);
        end else if (bfe_pkg::is_op(cur)) begin
          bad <= 1'b1;
        end else begin
          vstk[vsp[AW-1:0]] <= item.assignment[4'(wbuf[pc[AW-1:0]])];
          vsp <= vsp + SW'(1);
          pc  <= pc + LW'(1);
          expect_opnd <= 1'b0;
        end
      end else if (otop == bfe_pkg::CH_NOT) begin
        vstk[vsp[AW-1:0] - AW'(1)] <= ~vstk[vsp[AW-1:0] - AW'(1)];
        osp <= osp - SW'(1);
      end else if (bfe_pkg::prec(otop) != 3'd0 &&
                   (at_end || cur == bfe_pkg::CH_RP ||
                    bfe_pkg::prec(otop) >= bfe_pkg::prec(cur))) begin
        vstk[vsp[AW-1:0] - AW'(2)] <= bfe_pkg::apply(otop, vstk[vsp[AW-1:0] - AW'(2)],
                                                     vstk[vsp[AW-1:0] - AW'(1)]);
        vsp <= vsp - SW'(1);
        osp <= osp - SW'(1);
      end else if (at_end) begin
        if (osp != '0) bad <= 1'b1;
        done <= 1'b1;
      end else if (cur == bfe_pkg::CH_RP) begin
        if (otop == bfe_pkg::CH_LP) begin
          osp <= osp - SW'(1);
          pc  <= pc + LW'(1);
        end else begin
          bad <= 1'b1;
        end
      end else if (bfe_pkg::prec(cur) != 3'd0) begin
        ostk[osp[AW-1:0]] <= cur;
        osp <= osp + SW'(1);
        pc  <= pc + LW'(1);
        expect_opnd <= 1'b1;
      end else begin
        bad <= 1'b1;
      end
    end
  end
endmodule

// ===== sv/bfe_control.sv =====
// Controller: handshake, load sequencing, status and result register.
module bfe_control (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  bfe_pkg::in_item_t in_item,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output bfe_pkg::out_item_t out_item,
  output bfe_pkg::dp_cmd_t  cmd,
  input  bfe_pkg::dp_sts_t  sts,
  input  logic [4:0]        var_total,
  input  logic              eval_value,
  input  logic              eval_bad
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_STORE, S_CHECK, S_EVAL, S_OUT} state_t;
  state_t     state;
  logic       complete, last;
  logic [1:0] lstat;

  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd = '0;
    cmd.take = state == S_IDLE && in_valid;
    cmd.clear = cmd.take && in_item.command == bfe_pkg::CMD_LOAD && complete;
    cmd.scan_start = cmd.take;
    cmd.eval_start = cmd.take;
    cmd.scan_step = state == S_SCAN;
    cmd.store = state == S_STORE && !sts.full;
    cmd.add_var = state == S_STORE && !sts.full && sts.is_var;
    cmd.eval_step = state == S_CHECK || state == S_EVAL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      complete  <= 1'b0;
      lstat     <= bfe_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            last    <= in_item.last_char;
            if (in_item.command == bfe_pkg::CMD_EVAL) begin
              if (!complete || lstat != bfe_pkg::ST_OK) begin
                out_item.value  <= 1'b0;
                out_item.status <= (lstat != bfe_pkg::ST_OK) ? lstat
                                                            : bfe_pkg::ST_MALFORM;
                out_item.variable_count <= var_total;
                out_valid <= 1'b1;
                state     <= S_OUT;
              end else begin
                state <= S_EVAL;
              end
            end else begin
              if (complete) begin
                complete <= 1'b0;
                lstat    <= bfe_pkg::ST_OK;
              end
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (sts.scan_done) state <= S_STORE;
        end
        S_STORE: begin
          if (sts.full) begin
            if (lstat == bfe_pkg::ST_OK) lstat <= bfe_pkg::ST_LONG;
          end else if (sts.var_over && lstat == bfe_pkg::ST_OK) begin
            lstat <= bfe_pkg::ST_VARS;
          end
          state <= S_IDLE;
          if (last) begin
            complete <= 1'b1;
            state    <= S_CHECK;
          end
        end
        S_CHECK, S_EVAL: begin
          if (sts.eval_done) begin
            out_item.variable_count <= var_total;
            if (state == S_CHECK) begin
              out_item.value <= 1'b0;
              if (lstat == bfe_pkg::ST_OK && eval_bad) begin
                lstat <= bfe_pkg::ST_MALFORM;
                out_item.status <= bfe_pkg::ST_MALFORM;
              end else begin
                out_item.status <= lstat;
              end
            end else begin
              out_item.value  <= eval_bad ? 1'b0 : eval_value;
              out_item.status <= eval_bad ? bfe_pkg::ST_MALFORM : bfe_pkg::ST_OK;
            end
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/boolean_formula_evaluator.sv =====
// Top level: boolean formula evaluator.
// Input channel in_valid/in_stall carries in_item: a load (command 0) stores
// one character; the item flagged last_char returns variable count and
// status. An evaluate (command 1) maps assignment bit g to variable g and
// returns the truth value. Output channel out_valid/out_stall carries out_item.
// Items are handled one at a time. A load latches the item, searches the
// table of known variables and stores the character; a final load or
// evaluate then runs the single operator/value stack evaluator over every
// character and reduction until it is done.
// A result is held in the output register until taken; while it waits the
// input is stalled. Reset clears the formula, counts, status and the
// output valid; stored characters need no clearing.
module boolean_formula_evaluator #(
  parameter int MAX_LEN  = bfe_pkg::MAX_LEN_DEF,
  parameter int MAX_VARS = bfe_pkg::MAX_VARS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bfe_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output bfe_pkg::out_item_t out_item
);
  bfe_pkg::dp_cmd_t cmd;
  bfe_pkg::dp_sts_t sts;
  logic [4:0] var_total;
  logic       eval_value, eval_bad;

  bfe_control u_ctl (
    .clk, .rst, .in_valid, .in_item, .in_stall, .out_valid, .out_stall,
    .out_item, .cmd, .sts, .var_total, .eval_value, .eval_bad
  );

  bfe_datapath #(.MAX_LEN(MAX_LEN), .MAX_VARS(MAX_VARS)) u_dp (
    .clk, .rst, .in_item, .cmd, .sts, .var_total, .eval_value, .eval_bad
  );
endmodule
